[sv/cfrp_pkg.sv]
// shared types and constants for the command frame receive parser
// no dependencies; imported by every module of the block

package cfrp_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned ID_W     = 16;
  localparam int unsigned CFG_IDX_W = 8;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_START  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_START = 8'd1;

  // reset values of the sync bytes
  localparam logic [BYTE_W-1:0] FIRST_START_RESET  = 8'd34;
  localparam logic [BYTE_W-1:0] SECOND_START_RESET = 8'd105;

  // header bytes counted by the length byte
  localparam logic [BYTE_W-1:0] MIN_LENGTH = 8'd6;

  // result kinds
  localparam logic KIND_HEADER  = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [ID_W-1:0]   hw_id;
    logic [ID_W-1:0]   message_id;
    logic [BYTE_W-1:0] route;
    logic [BYTE_W-1:0] opcode;
    logic [BYTE_W-1:0] message_length;
    logic [BYTE_W-1:0] payload_byte;
    logic [BYTE_W-1:0] payload_index;
    logic              last;
  } frame_result_t;

endpackage

[sv/cfrp_front.sv]
// front end: sync byte hunt, header capture and result classification
// depends on cfrp_pkg; pushes finished results into cfrp_queue

module cfrp_front import cfrp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [BYTE_W-1:0]    rx_byte,
  input  logic                 queue_full,
  output logic                 push,
  output frame_result_t        push_data
);

  localparam logic [3:0] PH_START0  = 4'd0;
  localparam logic [3:0] PH_START1  = 4'd1;
  localparam logic [3:0] PH_LEN     = 4'd2;
  localparam logic [3:0] PH_HW_LO   = 4'd3;
  localparam logic [3:0] PH_HW_HI   = 4'd4;
  localparam logic [3:0] PH_ID_LO   = 4'd5;
  localparam logic [3:0] PH_ID_HI   = 4'd6;
  localparam logic [3:0] PH_ROUTE   = 4'd7;
  localparam logic [3:0] PH_OPCODE  = 4'd8;
  localparam logic [3:0] PH_PAYLOAD = 4'd9;

  logic [BYTE_W-1:0] first_start_byte;
  logic [BYTE_W-1:0] second_start_byte;
  logic [3:0]        phase;
  logic [3:0]        phase_next;
  logic [ID_W-1:0]   held_hw_id;
  logic [ID_W-1:0]   held_message_id;
  logic [BYTE_W-1:0] held_length;
  logic [BYTE_W-1:0] held_route;
  logic [BYTE_W-1:0] held_opcode;
  logic [BYTE_W-1:0] payload_remaining;
  logic [BYTE_W-1:0] payload_position;
  logic              emits;
  logic              accept;
  logic              fin_header;
  logic              fin_payload;

  // only the opcode and payload phases produce a result
  assign emits      = (phase == PH_OPCODE) || (phase == PH_PAYLOAD);
  assign in_ready   = !emits || !queue_full;
  assign accept     = in_valid && in_ready;
  assign fin_header  = (payload_remaining == '0);
  assign fin_payload = (payload_remaining <= 8'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      first_start_byte  <= FIRST_START_RESET;
      second_start_byte <= SECOND_START_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_FIRST_START) begin
        first_start_byte <= cfg_data;
      end else if (cfg_index == CFG_SECOND_START) begin
        second_start_byte <= cfg_data;
      end
    end
  end

  always_comb begin
    phase_next = phase;
    case (phase)
      PH_START1:  phase_next = (rx_byte == second_start_byte) ? PH_LEN : PH_START0;
      PH_LEN:     phase_next = (rx_byte >= MIN_LENGTH) ? PH_HW_LO : PH_START0;
      PH_HW_LO:   phase_next = PH_HW_HI;
      PH_HW_HI:   phase_next = PH_ID_LO;
      PH_ID_LO:   phase_next = PH_ID_HI;
      PH_ID_HI:   phase_next = PH_ROUTE;
      PH_ROUTE:   phase_next = PH_OPCODE;
      PH_OPCODE:  phase_next = fin_header ? PH_START0 : PH_PAYLOAD;
      PH_PAYLOAD: phase_next = fin_payload ? PH_START0 : PH_PAYLOAD;
      default:    phase_next = (rx_byte == first_start_byte) ? PH_START1 : PH_START0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_START0;
      payload_remaining <= '0;
      payload_position  <= '0;
    end else if (accept) begin
      phase <= phase_next;
      case (phase)
        PH_START1: begin
          payload_remaining <= '0;
          payload_position  <= '0;
        end
        PH_LEN: begin
          payload_remaining <= (rx_byte >= MIN_LENGTH) ? (rx_byte - MIN_LENGTH) : '0;
          payload_position  <= '0;
        end
        PH_PAYLOAD: begin
          payload_remaining <= fin_payload ? '0 : (payload_remaining - 8'd1);
          payload_position  <= fin_payload ? '0 : (payload_position + 8'd1);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_hw_id      <= '0;
      held_message_id <= '0;
      held_length     <= '0;
      held_route      <= '0;
      held_opcode     <= '0;
    end else if (accept) begin
      case (phase)
        PH_LEN:    if (rx_byte >= MIN_LENGTH) held_length <= rx_byte;
        PH_HW_LO:  held_hw_id[7:0]       <= rx_byte;
        PH_HW_HI:  held_hw_id[15:8]      <= rx_byte;
        PH_ID_LO:  held_message_id[7:0]  <= rx_byte;
        PH_ID_HI:  held_message_id[15:8] <= rx_byte;
        PH_ROUTE:  held_route            <= rx_byte;
        PH_OPCODE: held_opcode           <= rx_byte;
        default: begin
        end
      endcase
    end
  end

  // the header result takes the opcode straight from the incoming beat
  assign push = accept && emits;

  always_comb begin
    push_data.hw_id          = held_hw_id;
    push_data.message_id     = held_message_id;
    push_data.route          = held_route;
    push_data.message_length = held_length;
    if (phase == PH_OPCODE) begin
      push_data.kind          = KIND_HEADER;
      push_data.opcode        = rx_byte;
      push_data.payload_byte  = '0;
      push_data.payload_index = '0;
      push_data.last          = fin_header;
    end else begin
      push_data.kind          = KIND_PAYLOAD;
      push_data.opcode        = held_opcode;
      push_data.payload_byte  = rx_byte;
      push_data.payload_index = payload_position;
      push_data.last          = fin_payload;
    end
  end

endmodule

[sv/cfrp_queue.sv]
// small result queue between the front end and the output stage
// depends on cfrp_pkg for the result type

module cfrp_queue import cfrp_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  frame_result_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output frame_result_t pop_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  frame_result_t    mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == FULL_CNT);
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : (wr_ptr + 1'b1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : (rd_ptr + 1'b1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[sv/cfrp_back.sv]
// output stage: registered result beat toward the receiver
// depends on cfrp_pkg; drains cfrp_queue

module cfrp_back import cfrp_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          queue_empty,
  input  frame_result_t queue_data,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output frame_result_t out_data
);

  logic load;

  assign load = !queue_empty && (!out_valid || out_ready);
  assign pop  = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= queue_data;
    end
  end

endmodule

[sv/command_frame_receive_parser.sv]
// top level of the command frame receive parser
// depends on cfrp_pkg, cfrp_front, cfrp_queue and cfrp_back
//
// usage:
// - input channel: one received serial byte per beat (in_valid / in_ready / rx_byte)
// - output channel: one result per beat, a header result on the opcode byte of a
//   frame, then one result per payload byte; last marks the final result of a frame
// - config channel: cfg_index 0 sets the first sync byte, 1 the second; other
//   indexes are accepted and ignored; cfg_ready is always high
// - throughput: one byte per cycle while in_ready is high, and the output stage
//   issues one result per cycle while the queue holds results and out_ready is high
// - result path: the result of an accepted byte is written into the queue, then
//   into the output register
// - stall: when the receiver holds out_ready low the queue fills; once full,
//   in_ready drops only in the opcode and payload phases, earlier header bytes keep flowing
// - reset: synchronous, clears the parse state, the queue and the output valid,
//   and restores the sync bytes to 34 and 105

module command_frame_receive_parser import cfrp_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [BYTE_W-1:0]    rx_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 kind,
  output logic [ID_W-1:0]      hw_id,
  output logic [ID_W-1:0]      message_id,
  output logic [BYTE_W-1:0]    route,
  output logic [BYTE_W-1:0]    opcode,
  output logic [BYTE_W-1:0]    message_length,
  output logic [BYTE_W-1:0]    payload_byte,
  output logic [BYTE_W-1:0]    payload_index,
  output logic                 last
);

  logic          queue_full;
  logic          queue_empty;
  logic          push;
  logic          pop;
  frame_result_t push_data;
  frame_result_t queue_data;
  frame_result_t out_data;

  // config writes are always accepted and go straight into the sync byte registers
  assign cfg_ready = 1'b1;

  cfrp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .queue_full (queue_full),
    .push       (push),
    .push_data  (push_data)
  );

  // decouples parsing from a stalled receiver
  cfrp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (queue_full),
    .pop       (pop),
    .empty     (queue_empty),
    .pop_data  (queue_data)
  );

  cfrp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .queue_empty (queue_empty),
    .queue_data  (queue_data),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

  // unpack the result beat onto the field ports
  assign kind           = out_data.kind;
  assign hw_id          = out_data.hw_id;
  assign message_id     = out_data.message_id;
  assign route          = out_data.route;
  assign opcode         = out_data.opcode;
  assign message_length = out_data.message_length;
  assign payload_byte   = out_data.payload_byte;
  assign payload_index  = out_data.payload_index;
  assign last           = out_data.last;

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// self-checking testbench for command_frame_receive_parser: byte stream in, frame results out
// depends on cfrp_pkg and the block's RTL; carries its own frame parser to predict results

module tb;
  import cfrp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned HOLD_CYCLES = 400;   // long receiver hold-off for the pressure test
  localparam int unsigned DRAIN_CYCLES = 8;    // settling margin after the last owed result arrives
  localparam int unsigned MAX_REPORTS = 10;

  // parse phases of the predictor
  typedef enum logic [3:0] {
    WAIT_FIRST, WAIT_SECOND, GET_LENGTH, GET_HW_LO, GET_HW_HI,
    GET_ID_LO, GET_ID_HI, GET_ROUTE, GET_OPCODE, GET_PAYLOAD
  } parse_phase_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [BYTE_W-1:0]    cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [BYTE_W-1:0]    rx_byte = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 kind;
  logic [ID_W-1:0]      hw_id;
  logic [ID_W-1:0]      message_id;
  logic [BYTE_W-1:0]    route;
  logic [BYTE_W-1:0]    opcode;
  logic [BYTE_W-1:0]    message_length;
  logic [BYTE_W-1:0]    payload_byte;
  logic [BYTE_W-1:0]    payload_index;
  logic                 last;

  command_frame_receive_parser dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kind           (kind),
    .hw_id          (hw_id),
    .message_id     (message_id),
    .route          (route),
    .opcode         (opcode),
    .message_length (message_length),
    .payload_byte   (payload_byte),
    .payload_index  (payload_index),
    .last           (last)
  );

  // ---------------------------------------------------------------------------
  // parser predictor state, kept in step with every accepted byte
  // ---------------------------------------------------------------------------
  parse_phase_t      phase = WAIT_FIRST;
  logic [BYTE_W-1:0] sync_first = FIRST_START_RESET;
  logic [BYTE_W-1:0] sync_second = SECOND_START_RESET;
  logic [ID_W-1:0]   frame_hw_id = '0;
  logic [ID_W-1:0]   frame_msg_id = '0;
  logic [BYTE_W-1:0] frame_length = '0;
  logic [BYTE_W-1:0] frame_route = '0;
  logic [BYTE_W-1:0] frame_opcode = '0;
  logic [BYTE_W-1:0] bytes_left = '0;   // payload bytes still to come
  logic [BYTE_W-1:0] next_index = '0;   // payload position of the next byte

  frame_result_t pending_results[$];    // results the block still owes, oldest first

  // knobs set by the test tasks
  int unsigned in_idle_pct = 0;
  int unsigned out_stall_pct = 0;
  logic        receiver_hold = 1'b0;
  event        hold_go;

  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned bytes_sent = 0;

  frame_result_t seen_result;
  frame_result_t want_result;

  assign seen_result = {kind, hw_id, message_id, route, opcode, message_length,
                        payload_byte, payload_index, last};

  // ---------------------------------------------------------------------------
  // clock and watchdog
  // ---------------------------------------------------------------------------
  initial forever #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycle_count,
               pending_results.size());
      $display("command_frame_receive_parser regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // receiver side: random stalls, plus the long hold-off on request
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_ready <= !receiver_hold && ($urandom_range(99) >= out_stall_pct);
  end

  // hold-off counted here so the sender keeps offering beats meanwhile
  initial forever begin
    @(hold_go);
    receiver_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    receiver_hold <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // result checker: every output beat against the oldest owed result
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        if (fail_count < MAX_REPORTS)
          $display("unexpected result beat: kind=%0d hw=%h msg=%h len=%0d byte=%h idx=%0d",
                   seen_result.kind, seen_result.hw_id, seen_result.message_id,
                   seen_result.message_length, seen_result.payload_byte,
                   seen_result.payload_index);
        fail_count <= fail_count + 1;
      end else begin
        want_result = pending_results.pop_front();
        if (seen_result !== want_result) begin
          if (fail_count < MAX_REPORTS) begin
            $display({"mismatch exp: kind=%0d hw=%h msg=%h route=%h op=%h len=%0d",
                      " byte=%h idx=%0d last=%0d"},
                     want_result.kind, want_result.hw_id, want_result.message_id,
                     want_result.route, want_result.opcode, want_result.message_length,
                     want_result.payload_byte, want_result.payload_index, want_result.last);
            $display({"         got: kind=%0d hw=%h msg=%h route=%h op=%h len=%0d",
                      " byte=%h idx=%0d last=%0d"},
                     seen_result.kind, seen_result.hw_id, seen_result.message_id,
                     seen_result.route, seen_result.opcode, seen_result.message_length,
                     seen_result.payload_byte, seen_result.payload_index, seen_result.last);
          end
          fail_count <= fail_count + 1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // predictor: advance the parse by one accepted byte, queue any result
  // ---------------------------------------------------------------------------
  function automatic void track_rx_byte(input logic [BYTE_W-1:0] b);
    frame_result_t r;
    logic          emit;
    logic          done;
    emit = 1'b0;
    done = 1'b0;
    r = '0;
    case (phase)
      WAIT_SECOND: begin
        // a mismatch goes back to waiting without re-testing this byte
        phase = (b == sync_second) ? GET_LENGTH : WAIT_FIRST;
        bytes_left = '0;
        next_index = '0;
      end
      GET_LENGTH: begin
        if (b >= MIN_LENGTH) begin
          frame_length = b;
          bytes_left = b - MIN_LENGTH;
          next_index = '0;
          phase = GET_HW_LO;
        end else begin
          // short length drops the frame
          bytes_left = '0;
          next_index = '0;
          phase = WAIT_FIRST;
        end
      end
      GET_HW_LO: begin
        frame_hw_id[7:0] = b;
        phase = GET_HW_HI;
      end
      GET_HW_HI: begin
        frame_hw_id[15:8] = b;
        phase = GET_ID_LO;
      end
      GET_ID_LO: begin
        frame_msg_id[7:0] = b;
        phase = GET_ID_HI;
      end
      GET_ID_HI: begin
        frame_msg_id[15:8] = b;
        phase = GET_ROUTE;
      end
      GET_ROUTE: begin
        frame_route = b;
        phase = GET_OPCODE;
      end
      GET_OPCODE: begin
        frame_opcode = b;
        done = (bytes_left == 0);
        emit = 1'b1;
        r.kind = KIND_HEADER;
        phase = done ? WAIT_FIRST : GET_PAYLOAD;
      end
      GET_PAYLOAD: begin
        done = (bytes_left <= 1);
        emit = 1'b1;
        r.kind = KIND_PAYLOAD;
        r.payload_byte = b;
        r.payload_index = next_index;
        next_index = next_index + 8'd1;
        bytes_left = done ? '0 : bytes_left - 8'd1;
        if (done) begin
          phase = WAIT_FIRST;
          next_index = '0;
        end
      end
      default: begin
        phase = (b == sync_first) ? WAIT_SECOND : WAIT_FIRST;
      end
    endcase
    if (emit) begin
      r.hw_id = frame_hw_id;
      r.message_id = frame_msg_id;
      r.route = frame_route;
      r.opcode = frame_opcode;
      r.message_length = frame_length;
      r.last = done;
      pending_results.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // one byte beat; valid is left high after acceptance so back-to-back beats
  // never drop it; it is lowered before a random gap and by stop_sending
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int unsigned gap;
    gap = 0;
    while (gap < 100 && $urandom_range(99) < in_idle_pct)
      gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    track_rx_byte(b);
    bytes_sent++;
  endtask

  task automatic stop_sending();
    in_valid <= 1'b0;
  endtask

  // block is idle once every owed result is out and the parse stage has settled
  task automatic wait_until_idle();
    stop_sending();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [BYTE_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_FIRST_START)
      sync_first = data;
    else if (idx == CFG_SECOND_START)
      sync_second = data;
  endtask

  // both sync bytes plus a write to an unused index, which must do nothing
  task automatic set_sync_bytes(input logic [BYTE_W-1:0] first,
                                input logic [BYTE_W-1:0] second);
    logic [CFG_IDX_W-1:0] junk_idx;
    junk_idx = CFG_IDX_W'($urandom_range(2, 255));
    wait_until_idle();
    write_register(CFG_FIRST_START, first);
    write_register(junk_idx, BYTE_W'($urandom_range(255)));
    write_register(CFG_SECOND_START, second);
    cfg_valid <= 1'b0;
  endtask

  // a well-formed frame: syncs, length, ids low byte first, route, opcode, payload
  task automatic send_frame(input logic [BYTE_W-1:0] len, input logic [ID_W-1:0] hw,
                            input logic [ID_W-1:0] msg, input logic [BYTE_W-1:0] rte,
                            input logic [BYTE_W-1:0] op);
    send_byte(sync_first);
    send_byte(sync_second);
    send_byte(len);
    send_byte(hw[7:0]);
    send_byte(hw[15:8]);
    send_byte(msg[7:0]);
    send_byte(msg[15:8]);
    send_byte(rte);
    send_byte(op);
    for (int i = 0; i < int'(len) - int'(MIN_LENGTH); i++)
      send_byte(BYTE_W'($urandom_range(255)));
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset sync bytes: wrong first byte, repeated first byte as second, short
  // length, minimum length frame and a one-byte payload, fields at extremes
  task automatic test_sync_detection();
    send_byte(8'h00);
    send_byte(8'hFF);
    // second byte equal to the first sync byte is not re-tested, so the
    // following second sync byte is just noise
    send_byte(FIRST_START_RESET);
    send_byte(FIRST_START_RESET);
    send_byte(SECOND_START_RESET);
    // one below the minimum length drops the frame
    send_byte(FIRST_START_RESET);
    send_byte(SECOND_START_RESET);
    send_byte(MIN_LENGTH - 8'd1);
    // length of exactly six ends on the header result
    send_frame(MIN_LENGTH, 16'hFFFF, 16'h0000, 8'hFF, 8'h00);
    send_frame(MIN_LENGTH + 8'd1, 16'h0000, 16'hFFFF, 8'h00, 8'hFF);
    wait_until_idle();
  endtask

  // sync bytes at the extremes, and the same value for both
  task automatic test_sync_registers();
    set_sync_bytes(8'h00, 8'hFF);
    send_byte(8'h01);
    send_frame(8'd8, 16'h1234, 16'hABCD, 8'h5A, 8'hC3);
    set_sync_bytes(8'hFF, 8'h00);
    send_frame(MIN_LENGTH, 16'h8001, 16'h7FFE, 8'h81, 8'h7E);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h00);
    set_sync_bytes(8'hA5, 8'hA5);
    send_frame(8'd10, ID_W'($urandom_range(65535)), ID_W'($urandom_range(65535)),
               8'h12, 8'h34);
    wait_until_idle();
  endtask

  // longest frame while the receiver holds off: the queue fills and the
  // input must stall in the payload phase
  task automatic test_backpressure();
    in_idle_pct = 0;
    out_stall_pct = 0;
    -> hold_go;
    send_frame(8'hFF, ID_W'($urandom_range(65535)), ID_W'($urandom_range(65535)),
               BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)));
    wait_until_idle();
  endtask

  // mostly well-formed frames with random content, mixed with broken frames and noise
  task automatic test_random_traffic(input int unsigned n_bytes,
                                     input int unsigned idle_pct,
                                     input int unsigned stall_pct,
                                     input logic [BYTE_W-1:0] first,
                                     input logic [BYTE_W-1:0] second);
    int unsigned       start;
    int unsigned       pick;
    int unsigned       len;
    logic [BYTE_W-1:0] bad;
    set_sync_bytes(first, second);
    in_idle_pct = idle_pct;
    out_stall_pct = stall_pct;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        // mostly short frames, now and then a long one
        pick = $urandom_range(99);
        if (pick < 80)
          len = $urandom_range(6, 16);
        else if (pick < 95)
          len = $urandom_range(17, 60);
        else
          len = $urandom_range(61, 255);
        send_frame(BYTE_W'(len), ID_W'($urandom_range(65535)),
                   ID_W'($urandom_range(65535)),
                   BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)));
      end else if (pick < 80) begin
        // wrong second sync byte, often the first sync byte again
        bad = ($urandom_range(2) == 0) ? sync_first : BYTE_W'($urandom_range(255));
        if (bad == sync_second)
          bad = bad + 8'd1;
        send_byte(sync_first);
        send_byte(bad);
      end else if (pick < 88) begin
        send_byte(sync_first);
        send_byte(sync_second);
        send_byte(BYTE_W'($urandom_range(0, MIN_LENGTH - 1)));
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(BYTE_W'($urandom_range(255)));
      end
    end
    wait_until_idle();
  endtask

  // ---------------------------------------------------------------------------
  // run
  // ---------------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_sync_detection();
    test_sync_registers();
    test_backpressure();
    // no idling, then sender idle, receiver stalling, and both a little
    test_random_traffic(280, 0, 0, BYTE_W'($urandom_range(255)),
                        BYTE_W'($urandom_range(255)));
    test_random_traffic(280, 88, 0, 8'h5A, 8'h5A);
    test_random_traffic(285, 0, 88, FIRST_START_RESET, SECOND_START_RESET);
    test_random_traffic(285, 15, 15, BYTE_W'($urandom_range(255)),
                        BYTE_W'($urandom_range(255)));

    stop_sending();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0d results never arrived", pending_results.size());
      fail_count += pending_results.size();
    end

    if (fail_count == 0) begin
      $display("command_frame_receive_parser regression: pass");
    end else begin
      $display("command_frame_receive_parser regression: fail");
    end
    $finish;
  end

endmodule
